// ----- rtl/stt_pkg.sv -----
// Package for the source text tokenizer: sizes, mode and token codes,
// character class and keyword helpers. No dependencies.
package stt_pkg;

	localparam int COMMENT_DEPTH = 8;
	localparam int POSITION_BITS = 16;
	localparam int DEPTH_BITS = $clog2(COMMENT_DEPTH + 1);
	localparam int STACK_IDX_BITS = (COMMENT_DEPTH > 1) ? $clog2(COMMENT_DEPTH) : 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;
	localparam logic [30:0] NUM_MAX = 31'h7FFFFFFF;

	typedef enum logic [3:0] {
		MD_IDLE, MD_SLASH, MD_OP, MD_NUM, MD_WORD, MD_STR, MD_LCOM,
		MD_BOPEN, MD_BBODY, MD_BSLASH, MD_BSTARS, MD_ERR
	} mode_t;

	localparam logic [5:0] K_END = 6'd0;
	localparam logic [5:0] K_SLASH = 6'd12;
	localparam logic [5:0] K_STRING = 6'd23;
	localparam logic [5:0] K_NUMBER = 6'd24;
	localparam logic [5:0] K_IDENT = 6'd25;
	localparam logic [5:0] K_TYPE = 6'd26;
	localparam logic [5:0] K_UNKNOWN = 6'd34;
	localparam logic [5:0] K_ERROR = 6'd35;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_NEWLINE = 2'd1;
	localparam logic [1:0] ERR_EOF = 2'd2;

	// one emitted token, position taken from the scanner at emit time
	typedef struct packed {
		logic [5:0]  kind;
		logic [1:0]  tname;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] length;
		logic [30:0] value;
		logic [1:0]  err;
	} token_t;

	// up to two tokens per input transfer
	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} emit_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
	endfunction

	function automatic logic [15:0] clamp16(input logic [POSITION_BITS-1:0] v);
		if (POSITION_BITS > 16 && v > POSITION_BITS'(16'hFFFF))
			return 16'hFFFF;
		return 16'(v);
	endfunction

	function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	// single-character punctuation: kind, or 0 if none
	function automatic logic [5:0] single_kind(input logic [7:0] c);
		case (c)
			8'h28: return 6'd1;
			8'h29: return 6'd2;
			8'h5B: return 6'd3;
			8'h5D: return 6'd4;
			8'h7B: return 6'd5;
			8'h7D: return 6'd6;
			8'h3A: return 6'd7;
			8'h3B: return 6'd8;
			8'h2B: return 6'd9;
			8'h2D: return 6'd10;
			8'h2A: return 6'd11;
			default: return 6'd0;
		endcase
	endfunction

	// operator lead character index 0..5, 7 if none
	function automatic logic [2:0] op_index(input logic [7:0] c);
		case (c)
			8'h21: return 3'd0;
			8'h3D: return 3'd1;
			8'h3C: return 3'd2;
			8'h3E: return 3'd3;
			8'h26: return 3'd4;
			8'h7C: return 3'd5;
			default: return 3'd7;
		endcase
	endfunction

	function automatic logic [7:0] op_pair(input logic [2:0] k);
		case (k)
			3'd4: return 8'h26;
			3'd5: return 8'h7C;
			default: return 8'h3D;
		endcase
	endfunction

	function automatic logic [5:0] op_kind2(input logic [2:0] k);
		case (k)
			3'd0: return 6'd16;
			3'd1: return 6'd18;
			3'd2: return 6'd19;
			3'd3: return 6'd21;
			3'd4: return 6'd13;
			default: return 6'd14;
		endcase
	endfunction

	function automatic logic [5:0] op_kind1(input logic [2:0] k);
		case (k)
			3'd0: return 6'd15;
			3'd1: return 6'd17;
			3'd2: return 6'd20;
			3'd3: return 6'd22;
			default: return K_UNKNOWN;
		endcase
	endfunction

	// keyword lookup on 7-byte prefix and length; kind K_IDENT if none
	function automatic logic [7:0] kw_lookup(input logic [55:0] p, input logic [15:0] n);
		logic [5:0] k;
		logic [1:0] t;
		k = K_IDENT;
		t = 2'd0;
		if (n == 16'd3 && p == 56'h746E69) begin k = K_TYPE; t = 2'd0; end
		else if (n == 16'd4 && p == 56'h6C6F6F62) begin k = K_TYPE; t = 2'd1; end
		else if (n == 16'd6 && p == 56'h676E69727473) begin k = K_TYPE; t = 2'd2; end
		else if (n == 16'd4 && p == 56'h65757274) k = 6'd27;
		else if (n == 16'd5 && p == 56'h65736C6166) k = 6'd28;
		else if (n == 16'd2 && p == 56'h6669) k = 6'd29;
		else if (n == 16'd4 && p == 56'h65736C65) k = 6'd30;
		else if (n == 16'd3 && p == 56'h726176) k = 6'd31;
		else if (n == 16'd5 && p == 56'h746E697270) k = 6'd32;
		else if (n == 16'd7 && p == 56'h6564756C636E69) k = 6'd33;
		return {k, t};
	endfunction

endpackage

// ----- rtl/source_text_tokenizer.sv -----
// Top level of the source text tokenizer: scanner and output queue.
// Depends on stt_pkg, stt_scanner, stt_outq.
// Streaming tokenizer: one source byte (or end-of-input mark) per transfer,
// one byte per cycle when the output is drained; a byte that yields two
// tokens stalls the input while the second token leaves the two-entry
// output register. Tokens appear in the cycle after their byte.
module source_text_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  token_kind,
	output logic [1:0]  type_name,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic [15:0] token_length,
	output logic [30:0] number_value,
	output logic [1:0]  error_code,
	output logic        last_of_run
);

	stt_pkg::emit_t  emit;
	stt_pkg::token_t tok;
	logic            busy, step;

	assign in_stall = busy;
	assign step = in_valid && !busy;

	stt_scanner u_scan (
		.clk(clk), .arst_n(arst_n), .step(step),
		.char_code(char_code), .end_of_input(end_of_input), .emit(emit)
	);

	stt_outq u_outq (
		.clk(clk), .arst_n(arst_n), .load(step), .emit(emit), .stall(out_stall),
		.busy(busy), .valid(out_valid), .tok(tok), .last(last_of_run)
	);

	assign token_kind = tok.kind;
	assign type_name = tok.tname;
	assign start_line = tok.line;
	assign start_column = tok.column;
	assign token_length = tok.length;
	assign number_value = tok.value;
	assign error_code = tok.err;

endmodule

// ----- rtl/stt_scanner.sv -----
// Scanner state and combinational next-state logic of the tokenizer.
// Depends on stt_pkg. Takes one accepted transfer, yields up to two tokens.
module stt_scanner (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           char_code,
	input  logic                 end_of_input,
	output stt_pkg::emit_t       emit
);

	stt_pkg::mode_t                      mode_q, mode_d;
	logic [stt_pkg::POSITION_BITS-1:0]   cline_q, cline_d, ccol_q, ccol_d;
	logic [stt_pkg::POSITION_BITS-1:0]   tline_q, tline_d, tcol_q, tcol_d;
	logic [15:0]                         cnt_q, cnt_d;
	logic [30:0]                         acc_q, acc_d;
	logic [55:0]                         pfx_q, pfx_d;
	logic [3:0]                          run_q, run_d;
	logic [stt_pkg::DEPTH_BITS-1:0]      depth_q, depth_d;
	logic [3:0]                          stack_q [stt_pkg::COMMENT_DEPTH];
	logic                                push;
	logic [stt_pkg::STACK_IDX_BITS-1:0]  push_idx;
	logic [3:0]                          push_val;
	logic [3:0]                          top;

	assign top = (depth_q != '0) ?
		stack_q[stt_pkg::STACK_IDX_BITS'(depth_q - 1'b1)] : 4'd0;

	always_comb begin
		stt_pkg::emit_t e;
		logic again;
		logic [34:0] prod;
		logic [7:0]  kw;
		logic [2:0]  k;
		logic [7:0]  c;
		logic        nl;
		logic [5:0]  sk;
		e = '0;
		c = char_code;
		nl = c == 8'h0A;
		mode_d = mode_q; cline_d = cline_q; ccol_d = ccol_q;
		tline_d = tline_q; tcol_d = tcol_q; cnt_d = cnt_q; acc_d = acc_q;
		pfx_d = pfx_q; run_d = run_q; depth_d = depth_q;
		push = 1'b0; push_idx = '0; push_val = run_q;
		again = 1'b0;
		prod = 35'(acc_q) * 35'd10 + 35'(c - 8'h30);
		kw = stt_pkg::kw_lookup(pfx_q, cnt_q);
		k = (run_q < 4'd6) ? run_q[2:0] : 3'd5;
		sk = stt_pkg::single_kind(c);

		if (end_of_input) begin
			// flush pending token, then end token, then restart
			e.t0.line = stt_pkg::clamp16(tline_q);
			e.t0.column = stt_pkg::clamp16(tcol_q);
			case (mode_q)
				stt_pkg::MD_SLASH: begin
					e.v0 = 1'b1; e.t0.kind = stt_pkg::K_SLASH; e.t0.length = 16'd1;
				end
				stt_pkg::MD_OP: begin
					e.v0 = 1'b1; e.t0.kind = stt_pkg::op_kind1(k); e.t0.length = 16'd1;
				end
				stt_pkg::MD_NUM: begin
					e.v0 = 1'b1; e.t0.kind = stt_pkg::K_NUMBER; e.t0.length = cnt_q;
					e.t0.value = acc_q;
				end
				stt_pkg::MD_WORD: begin
					e.v0 = 1'b1; e.t0.kind = kw[7:2]; e.t0.tname = kw[1:0];
					e.t0.length = cnt_q;
				end
				stt_pkg::MD_STR: begin
					e.v0 = 1'b1; e.t0.kind = stt_pkg::K_ERROR; e.t0.err = stt_pkg::ERR_EOF;
				end
				default: ;
			endcase
			e.t1 = '0;
			e.t1.kind = stt_pkg::K_END;
			e.t1.line = stt_pkg::clamp16(cline_q);
			e.t1.column = stt_pkg::clamp16(stt_pkg::pos_inc(ccol_q));
			e.v1 = 1'b1;
			if (!e.v0) begin e.t0 = e.t1; e.v0 = 1'b1; e.v1 = 1'b0; end
			mode_d = stt_pkg::MD_IDLE;
			cline_d = stt_pkg::POSITION_BITS'(1); ccol_d = '0;
			tline_d = stt_pkg::POSITION_BITS'(1); tcol_d = '0;
			cnt_d = '0; acc_d = '0; pfx_d = '0; run_d = '0; depth_d = '0;
		end else begin
			if (!nl) ccol_d = stt_pkg::pos_inc(ccol_q);
			// first pass over the pending mode
			case (mode_q)
				stt_pkg::MD_SLASH: begin
					if (c == 8'h2F) mode_d = stt_pkg::MD_LCOM;
					else if (c == 8'h2A) begin
						mode_d = stt_pkg::MD_BOPEN; run_d = 4'd1; depth_d = '0;
					end else begin
						e.v0 = 1'b1; e.t0.kind = stt_pkg::K_SLASH; e.t0.length = 16'd1;
						mode_d = stt_pkg::MD_IDLE; again = 1'b1;
					end
				end
				stt_pkg::MD_OP: begin
					mode_d = stt_pkg::MD_IDLE;
					e.v0 = 1'b1;
					if (c == stt_pkg::op_pair(k)) begin
						e.t0.kind = stt_pkg::op_kind2(k); e.t0.length = 16'd2;
					end else begin
						e.t0.kind = stt_pkg::op_kind1(k); e.t0.length = 16'd1; again = 1'b1;
					end
				end
				stt_pkg::MD_NUM: begin
					if (stt_pkg::is_digit(c)) begin
						acc_d = (prod > 35'(stt_pkg::NUM_MAX)) ? stt_pkg::NUM_MAX : prod[30:0];
						if (cnt_q != stt_pkg::LEN_MAX) cnt_d = cnt_q + 1'b1;
					end else begin
						e.v0 = 1'b1; e.t0.kind = stt_pkg::K_NUMBER; e.t0.length = cnt_q;
						e.t0.value = acc_q;
						mode_d = stt_pkg::MD_IDLE; again = 1'b1;
					end
				end
				stt_pkg::MD_WORD: begin
					if (stt_pkg::is_alpha(c) || stt_pkg::is_digit(c)) begin
						if (cnt_q < 16'd7) pfx_d = pfx_q | (56'(c) << {cnt_q[2:0], 3'b000});
						if (cnt_q != stt_pkg::LEN_MAX) cnt_d = cnt_q + 1'b1;
					end else begin
						e.v0 = 1'b1; e.t0.kind = kw[7:2]; e.t0.tname = kw[1:0];
						e.t0.length = cnt_q;
						mode_d = stt_pkg::MD_IDLE; again = 1'b1;
					end
				end
				stt_pkg::MD_STR: begin
					if (c == 8'h22) begin
						e.v0 = 1'b1; e.t0.kind = stt_pkg::K_STRING; e.t0.length = cnt_q;
						mode_d = stt_pkg::MD_IDLE;
					end else if (nl) begin
						e.v0 = 1'b1; e.t0.kind = stt_pkg::K_ERROR;
						e.t0.err = stt_pkg::ERR_NEWLINE;
						mode_d = stt_pkg::MD_ERR;
					end else if (cnt_q != stt_pkg::LEN_MAX) cnt_d = cnt_q + 1'b1;
				end
				stt_pkg::MD_LCOM: if (nl) mode_d = stt_pkg::MD_IDLE;
				stt_pkg::MD_BOPEN: begin
					if (c == 8'h2A) begin
						if (run_q != 4'd15) run_d = run_q + 1'b1;
					end else begin
						if (32'(depth_q) < stt_pkg::COMMENT_DEPTH) begin
							push = 1'b1;
							push_idx = stt_pkg::STACK_IDX_BITS'(depth_q);
							depth_d = depth_q + 1'b1;
						end
						// re-scan in body: only slash or star matter there
						mode_d = stt_pkg::MD_BBODY;
						if (c == 8'h2F) mode_d = stt_pkg::MD_BSLASH;
					end
				end
				stt_pkg::MD_BBODY: begin
					if (c == 8'h2F) mode_d = stt_pkg::MD_BSLASH;
					else if (c == 8'h2A) begin mode_d = stt_pkg::MD_BSTARS; run_d = 4'd1; end
				end
				stt_pkg::MD_BSLASH: begin
					if (c == 8'h2A) begin
						mode_d = (32'(depth_q) < stt_pkg::COMMENT_DEPTH) ?
							stt_pkg::MD_BOPEN : stt_pkg::MD_BBODY;
						run_d = 4'd1;
					end else if (c != 8'h2F) mode_d = stt_pkg::MD_BBODY;
				end
				stt_pkg::MD_BSTARS: begin
					if (c == 8'h2A) begin
						if (run_q != 4'd15) run_d = run_q + 1'b1;
					end else begin
						mode_d = stt_pkg::MD_BBODY;
						if (c == 8'h2F && depth_q != '0 && top == run_q) begin
							depth_d = depth_q - 1'b1;
							if (depth_q == 1) mode_d = stt_pkg::MD_IDLE;
						end
					end
				end
				stt_pkg::MD_ERR: ;
				default: again = 1'b1;
			endcase

			// idle scan, directly or after a flush
			if (again && !(c == 8'h20 || c == 8'h09 || nl)) begin
				tline_d = cline_q; tcol_d = ccol_d; cnt_d = 16'd1;
				if (sk != 6'd0) begin
					if (e.v0) begin
						e.v1 = 1'b1; e.t1.kind = sk; e.t1.length = 16'd1;
						e.t1.line = stt_pkg::clamp16(tline_d);
						e.t1.column = stt_pkg::clamp16(tcol_d);
					end else begin
						e.v0 = 1'b1; e.t0.kind = sk; e.t0.length = 16'd1;
					end
				end else if (stt_pkg::op_index(c) != 3'd7) begin
					mode_d = stt_pkg::MD_OP; run_d = {1'b0, stt_pkg::op_index(c)};
				end else if (c == 8'h2F) mode_d = stt_pkg::MD_SLASH;
				else if (c == 8'h22) begin mode_d = stt_pkg::MD_STR; cnt_d = '0; end
				else if (stt_pkg::is_digit(c)) begin
					mode_d = stt_pkg::MD_NUM; acc_d = 31'(c - 8'h30);
				end else if (stt_pkg::is_alpha(c)) begin
					mode_d = stt_pkg::MD_WORD; pfx_d = 56'(c);
				end else if (e.v0) begin
					e.v1 = 1'b1; e.t1.kind = stt_pkg::K_UNKNOWN; e.t1.length = 16'd1;
					e.t1.line = stt_pkg::clamp16(tline_d);
					e.t1.column = stt_pkg::clamp16(tcol_d);
				end else begin
					e.v0 = 1'b1; e.t0.kind = stt_pkg::K_UNKNOWN; e.t0.length = 16'd1;
				end
			end
			// first token uses the start position before this byte, or this byte's own from idle
			if (e.v0 && !again) begin
				e.t0.line = stt_pkg::clamp16(tline_q); e.t0.column = stt_pkg::clamp16(tcol_q);
			end else if (e.v0 && mode_q != stt_pkg::MD_IDLE) begin
				e.t0.line = stt_pkg::clamp16(tline_q); e.t0.column = stt_pkg::clamp16(tcol_q);
			end else if (e.v0) begin
				e.t0.line = stt_pkg::clamp16(tline_d); e.t0.column = stt_pkg::clamp16(tcol_d);
			end
			if (nl) begin cline_d = stt_pkg::pos_inc(cline_q); ccol_d = '0; end
		end
		emit = e;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MD_IDLE;
			cline_q <= stt_pkg::POSITION_BITS'(1); ccol_q <= '0;
			tline_q <= stt_pkg::POSITION_BITS'(1); tcol_q <= '0;
			cnt_q <= '0; acc_q <= '0; pfx_q <= '0; run_q <= '0; depth_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			cline_q <= cline_d; ccol_q <= ccol_d; tline_q <= tline_d; tcol_q <= tcol_d;
			cnt_q <= cnt_d; acc_q <= acc_d; pfx_q <= pfx_d; run_q <= run_d; depth_q <= depth_d;
		end
	end

	// star count stack, written on comment open
	always_ff @(posedge clk) begin
		if (step && push && !end_of_input) stack_q[push_idx] <= push_val;
	end

endmodule

// ----- rtl/stt_outq.sv -----
// Output side: holds up to two tokens of one transfer and hands them out
// one per cycle while the receiver does not stall. Depends on stt_pkg.
module stt_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  stt_pkg::emit_t      emit,
	input  logic                stall,
	output logic                busy,
	output logic                valid,
	output stt_pkg::token_t     tok,
	output logic                last
);

	stt_pkg::token_t t0_q, t1_q;
	logic            v0_q, v1_q;
	logic            take;

	assign valid = v0_q;
	assign tok = t0_q;
	assign last = !v1_q;
	assign take = v0_q && !stall;
	// can load when empty or when the last token leaves this cycle
	assign busy = v0_q && (v1_q || stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0; v1_q <= 1'b0;
		end else if (load) begin
			v0_q <= emit.v0; v1_q <= emit.v1;
		end else if (take) begin
			v0_q <= v1_q; v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			t0_q <= emit.t0; t1_q <= emit.t1;
		end else if (take) t0_q <= t1_q;
	end

endmodule

// ----- rtl/stt_checker.sv -----
// Port-level checker for the tokenizer, bound to the top level.
// Depends on stt_pkg.
module stt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        end_of_input,
	input logic        out_valid,
	input logic        out_stall,
	input logic [5:0]  token_kind,
	input logic [1:0]  error_code,
	input logic [15:0] start_line,
	input logic        last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind))
		else $error("stalled token changed");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != stt_pkg::ERR_NONE |-> token_kind == stt_pkg::K_ERROR)
		else $error("error code on non-error token");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == stt_pkg::K_END |-> last_of_run)
		else $error("end token not last");

	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> start_line != 16'd0)
		else $error("line zero");

	// an end-of-input transfer always yields a token on the next cycle
	a_eoi_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && end_of_input |=> out_valid)
		else $error("no token after end of input");

endmodule

bind source_text_tokenizer stt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.end_of_input(end_of_input), .out_valid(out_valid), .out_stall(out_stall),
	.token_kind(token_kind), .error_code(error_code), .start_line(start_line),
	.last_of_run(last_of_run)
);

// ----- tb/sv/tb_source_text_tokenizer.sv -----
// Testbench for source_text_tokenizer: a queued byte driver with bursts and gaps,
// a token predictor kept in step with the byte stream, and a monitor that checks tokens.
// Depends on stt_pkg and the source_text_tokenizer RTL.
module tb_source_text_tokenizer;

	// one byte or end mark to send
	typedef struct {
		logic [7:0] ch;
		logic       eoi;
	} src_byte_t;

	// one token that is still to arrive
	typedef struct {
		logic [5:0]  kind;
		logic [1:0]  tname;
		logic [15:0] line;
		logic [15:0] column;
		logic [15:0] length;
		logic [30:0] value;
		logic [1:0]  err;
		logic        last;
	} tok_exp_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] char_code;
	logic end_of_input;
	logic out_valid;
	logic out_stall;
	logic [5:0] token_kind;
	logic [1:0] type_name;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [15:0] token_length;
	logic [30:0] number_value;
	logic [1:0] error_code;
	logic last_of_run;

	src_byte_t pending_bytes[$];
	tok_exp_t expected_tokens[$];
	int fail_count = 0;
	bit stim_done = 0;

	// tokenizer state mirror
	stt_pkg::mode_t lx_mode;
	logic [15:0] lx_line, lx_col, lx_tline, lx_tcol, lx_count;
	logic [30:0] lx_num;
	logic [55:0] lx_prefix;
	logic [3:0] lx_stars [stt_pkg::COMMENT_DEPTH];
	int lx_depth;
	int lx_run;
	int step_n;

	source_text_tokenizer u_top (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void lx_reset();
		lx_mode = stt_pkg::MD_IDLE;
		lx_line = 16'd1;
		lx_col = 16'd0;
		lx_tline = 16'd1;
		lx_tcol = 16'd0;
		lx_count = 16'd0;
		lx_num = '0;
		lx_prefix = '0;
		lx_depth = 0;
		lx_run = 0;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic bit digit_c(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha_c(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
	endfunction

	function automatic void push_tok(input logic [5:0] k, input logic [1:0] t,
			input logic [15:0] len, input logic [30:0] val, input logic [1:0] e);
		tok_exp_t x;
		x.kind = k;
		x.tname = t;
		x.line = lx_tline;
		x.column = lx_tcol;
		x.length = len;
		x.value = val;
		x.err = e;
		x.last = 1'b0;
		expected_tokens.push_back(x);
		step_n++;
	endfunction

	// plain token with no type, value or error
	function automatic void push_plain(input logic [5:0] k, input logic [15:0] len);
		push_tok(k, 2'd0, len, 31'd0, stt_pkg::ERR_NONE);
	endfunction

	// keyword match on prefix and length
	function automatic void push_word();
		logic [5:0] k;
		logic [1:0] t;
		k = stt_pkg::K_IDENT;
		t = 2'd0;
		case (lx_count)
			16'd2: if (lx_prefix == 56'h6669) k = 6'd29;
			16'd3: if (lx_prefix == 56'h746E69) k = stt_pkg::K_TYPE;
				else if (lx_prefix == 56'h726176) k = 6'd31;
			16'd4: if (lx_prefix == 56'h6C6F6F62) begin
					k = stt_pkg::K_TYPE;
					t = 2'd1;
				end else if (lx_prefix == 56'h65757274) k = 6'd27;
				else if (lx_prefix == 56'h65736C65) k = 6'd30;
			16'd5: if (lx_prefix == 56'h65736C6166) k = 6'd28;
				else if (lx_prefix == 56'h746E697270) k = 6'd32;
			16'd6: if (lx_prefix == 56'h676E69727473) begin
					k = stt_pkg::K_TYPE;
					t = 2'd2;
				end
			16'd7: if (lx_prefix == 56'h6564756C636E69) k = 6'd33;
			default: ;
		endcase
		push_tok(k, t, lx_count, 31'd0, stt_pkg::ERR_NONE);
	endfunction

	function automatic logic [5:0] op_single_kind(input int k);
		case (k)
			0: return 6'd15;
			1: return 6'd17;
			2: return 6'd20;
			3: return 6'd22;
			default: return stt_pkg::K_UNKNOWN;
		endcase
	endfunction

	function automatic int op_lead(input logic [7:0] c);
		case (c)
			"!": return 0;
			"=": return 1;
			"<": return 2;
			">": return 3;
			"&": return 4;
			"|": return 5;
			default: return -1;
		endcase
	endfunction

	function automatic void count_up();
		if (lx_count != 16'hFFFF) lx_count++;
	endfunction

	function automatic void run_up();
		if (lx_run < 15) lx_run++;
	endfunction

	// scan one byte from the idle mode
	function automatic void lx_idle(input logic [7:0] c);
		int k;
		if (c == " " || c == "\t" || c == "\n") return;
		lx_tline = lx_line;
		lx_tcol = lx_col;
		lx_count = 16'd1;
		case (c)
			"(": begin push_plain(6'd1, 16'd1); return; end
			")": begin push_plain(6'd2, 16'd1); return; end
			"[": begin push_plain(6'd3, 16'd1); return; end
			"]": begin push_plain(6'd4, 16'd1); return; end
			"{": begin push_plain(6'd5, 16'd1); return; end
			"}": begin push_plain(6'd6, 16'd1); return; end
			":": begin push_plain(6'd7, 16'd1); return; end
			";": begin push_plain(6'd8, 16'd1); return; end
			"+": begin push_plain(6'd9, 16'd1); return; end
			"-": begin push_plain(6'd10, 16'd1); return; end
			"*": begin push_plain(6'd11, 16'd1); return; end
			default: ;
		endcase
		k = op_lead(c);
		if (k >= 0) begin
			lx_mode = stt_pkg::MD_OP;
			lx_run = k;
		end else if (c == "/") lx_mode = stt_pkg::MD_SLASH;
		else if (c == "\"") begin
			lx_mode = stt_pkg::MD_STR;
			lx_count = 16'd0;
		end else if (digit_c(c)) begin
			lx_mode = stt_pkg::MD_NUM;
			lx_num = 31'(c - "0");
		end else if (alpha_c(c)) begin
			lx_mode = stt_pkg::MD_WORD;
			lx_prefix = 56'(c);
		end else push_plain(stt_pkg::K_UNKNOWN, 16'd1);
	endfunction

	// scan one byte in a non-idle mode; 1 when the byte must be rescanned
	function automatic bit lx_scan(input logic [7:0] c);
		logic [34:0] v;
		int k;
		case (lx_mode)
			stt_pkg::MD_SLASH: begin
				if (c == "/") begin lx_mode = stt_pkg::MD_LCOM; return 0; end
				if (c == "*") begin
					lx_mode = stt_pkg::MD_BOPEN;
					lx_run = 1;
					lx_depth = 0;
					return 0;
				end
				push_plain(stt_pkg::K_SLASH, 16'd1);
				lx_mode = stt_pkg::MD_IDLE;
				return 1;
			end
			stt_pkg::MD_OP: begin
				k = lx_run < 6 ? lx_run : 5;
				lx_mode = stt_pkg::MD_IDLE;
				if (c == ((k == 4) ? "&" : (k == 5) ? "|" : "=")) begin
					case (k)
						0: push_plain(6'd16, 16'd2);
						1: push_plain(6'd18, 16'd2);
						2: push_plain(6'd19, 16'd2);
						3: push_plain(6'd21, 16'd2);
						4: push_plain(6'd13, 16'd2);
						default: push_plain(6'd14, 16'd2);
					endcase
					return 0;
				end
				push_plain(op_single_kind(k), 16'd1);
				return 1;
			end
			stt_pkg::MD_NUM: begin
				if (digit_c(c)) begin
					v = 35'(lx_num) * 35'd10 + 35'(c - "0");
					lx_num = (v > 35'(stt_pkg::NUM_MAX)) ? stt_pkg::NUM_MAX : 31'(v);
					count_up();
					return 0;
				end
				push_tok(stt_pkg::K_NUMBER, 2'd0, lx_count, lx_num, stt_pkg::ERR_NONE);
				lx_mode = stt_pkg::MD_IDLE;
				return 1;
			end
			stt_pkg::MD_WORD: begin
				if (alpha_c(c) || digit_c(c)) begin
					if (lx_count < 7) lx_prefix |= 56'(c) << (8 * lx_count);
					count_up();
					return 0;
				end
				push_word();
				lx_mode = stt_pkg::MD_IDLE;
				return 1;
			end
			stt_pkg::MD_STR: begin
				if (c == "\"") begin
					push_plain(stt_pkg::K_STRING, lx_count);
					lx_mode = stt_pkg::MD_IDLE;
				end else if (c == "\n") begin
					push_tok(stt_pkg::K_ERROR, 2'd0, 16'd0, 31'd0, stt_pkg::ERR_NEWLINE);
					lx_mode = stt_pkg::MD_ERR;
				end else count_up();
				return 0;
			end
			stt_pkg::MD_LCOM: begin
				if (c == "\n") lx_mode = stt_pkg::MD_IDLE;
				return 0;
			end
			stt_pkg::MD_BOPEN: begin
				if (c == "*") begin run_up(); return 0; end
				if (lx_depth < stt_pkg::COMMENT_DEPTH) begin
					lx_stars[lx_depth] = 4'(lx_run);
					lx_depth++;
				end
				lx_mode = stt_pkg::MD_BBODY;
				return 1;
			end
			stt_pkg::MD_BBODY: begin
				if (c == "/") lx_mode = stt_pkg::MD_BSLASH;
				else if (c == "*") begin
					lx_mode = stt_pkg::MD_BSTARS;
					lx_run = 1;
				end
				return 0;
			end
			stt_pkg::MD_BSLASH: begin
				if (c == "*") begin
					lx_mode = (lx_depth < stt_pkg::COMMENT_DEPTH) ?
						stt_pkg::MD_BOPEN : stt_pkg::MD_BBODY;
					lx_run = 1;
				end else if (c != "/") lx_mode = stt_pkg::MD_BBODY;
				return 0;
			end
			stt_pkg::MD_BSTARS: begin
				if (c == "*") begin run_up(); return 0; end
				lx_mode = stt_pkg::MD_BBODY;
				if (c == "/" && lx_depth > 0 && lx_depth <= stt_pkg::COMMENT_DEPTH &&
						lx_stars[lx_depth-1] == 4'(lx_run)) begin
					lx_depth--;
					if (lx_depth == 0) lx_mode = stt_pkg::MD_IDLE;
				end
				return 0;
			end
			stt_pkg::MD_ERR: return 0;
			default: begin
				lx_mode = stt_pkg::MD_IDLE;
				lx_idle(c);
				return 0;
			end
		endcase
	endfunction

	// predict the tokens caused by one accepted transfer
	function automatic void predict_tokens(input src_byte_t b);
		step_n = 0;
		if (b.eoi) begin
			case (lx_mode)
				stt_pkg::MD_SLASH: push_plain(stt_pkg::K_SLASH, 16'd1);
				stt_pkg::MD_OP: push_plain(op_single_kind(lx_run < 6 ? lx_run : 5), 16'd1);
				stt_pkg::MD_NUM:
					push_tok(stt_pkg::K_NUMBER, 2'd0, lx_count, lx_num, stt_pkg::ERR_NONE);
				stt_pkg::MD_WORD: push_word();
				stt_pkg::MD_STR:
					push_tok(stt_pkg::K_ERROR, 2'd0, 16'd0, 31'd0, stt_pkg::ERR_EOF);
				default: ;
			endcase
			lx_tline = lx_line;
			lx_tcol = sat_inc(lx_col);
			push_plain(stt_pkg::K_END, 16'd0);
			lx_reset();
		end else begin
			if (b.ch != "\n") lx_col = sat_inc(lx_col);
			if (lx_mode == stt_pkg::MD_IDLE) lx_idle(b.ch);
			else if (lx_scan(b.ch)) begin
				if (lx_mode == stt_pkg::MD_IDLE) lx_idle(b.ch);
				else void'(lx_scan(b.ch));
			end
			if (b.ch == "\n") begin
				lx_line = sat_inc(lx_line);
				lx_col = 16'd0;
			end
		end
		if (step_n > 0) expected_tokens[$].last = 1'b1;
	endfunction

	// stimulus helpers
	task automatic send_text(input string s);
		src_byte_t b;
		b.eoi = 1'b0;
		for (int i = 0; i < s.len(); i++) begin
			b.ch = s[i];
			pending_bytes.push_back(b);
		end
	endtask

	task automatic send_byte(input logic [7:0] c);
		src_byte_t b;
		b.ch = c;
		b.eoi = 1'b0;
		pending_bytes.push_back(b);
	endtask

	task automatic send_eoi();
		src_byte_t b;
		b.ch = 8'($urandom);
		b.eoi = 1'b1;
		pending_bytes.push_back(b);
	endtask

	function automatic string rand_word();
		string kws[12] = '{"int", "bool", "string", "true", "false", "if", "else",
			"var", "print", "include", "includes", "i_9"};
		string s;
		int n;
		logic [7:0] ch;
		if ($urandom_range(1, 0)) return kws[$urandom_range(11, 0)];
		n = $urandom_range(9, 1);
		s = "";
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1, 0)) ch = 8'("a" + $urandom_range(25, 0));
			else ch = (i == 0) ? "_" : 8'("0" + $urandom_range(9, 0));
			s = {s, $sformatf("%c", ch)};
		end
		return s;
	endfunction

	function automatic string rand_lexeme();
		string ops[18] = '{"(", ")", "[", "]", "{", "}", ":", ";", "+", "-", "*", "/",
			"&&", "||", "!=", "==", "<=", ">="};
		string leads[6] = '{"!", "=", "<", ">", "&", "|"};
		string sep[4] = '{" ", "\t", "\n", ""};
		string s;
		int n;
		case ($urandom_range(9, 0))
			0, 1: s = rand_word();
			2: begin
				n = $urandom_range(12, 1);
				s = "";
				for (int i = 0; i < n; i++)
					s = {s, $sformatf("%c", 8'("0" + $urandom_range(9, 0)))};
			end
			3: s = $urandom_range(3, 0) ? "\"str x\"" : "\"\"";
			4: s = "// note\n";
			5: begin
				n = $urandom_range(3, 1);
				s = "/";
				repeat (n) s = {s, "*"};
				s = {s, " a/b/ /* in */ ** x\n "};
				repeat (n) s = {s, "*"};
				s = {s, "/"};
			end
			6: s = leads[$urandom_range(5, 0)];
			default: s = ops[$urandom_range(17, 0)];
		endcase
		return {s, sep[$urandom_range(3, 0)]};
	endfunction

	// fill the byte queue
	initial begin
		string t;
		// directed: every token kind, keywords, operators and special cases
		send_text("( ) [ ] { } : ; + - * / && || ! != = == <= < >= > & | @");
		send_text("\n int bool string true false if else var print include x_1 includes");
		send_text(" 0 2147483647 99999999999 \"ab c\" \"\" // line /\n");
		send_text("/** a /* b */ c *** / **/ d */ q /* /*/*/*/*/*/*/*/* deep */");
		send_eoi();
		send_text("/* open comment");
		send_eoi();
		send_text("\"no close");
		send_eoi();
		send_text("\"break\nafter error 1 2");
		send_eoi();
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		send_text("id");
		send_eoi();
		// random: mostly well-formed streams, some raw noise bytes
		while (pending_bytes.size() < 520) begin
			for (int i = $urandom_range(40, 3); i > 0; i--) begin
				if ($urandom_range(15, 0) == 0) send_byte(8'($urandom));
				else begin
					t = rand_lexeme();
					send_text(t);
				end
			end
			send_eoi();
		end
		// a longer line of mixed tokens
		repeat (2) send_text("abcdefghijklmnopqrstuvwxyz 1234567890 ;;; /* c */ ");
		send_eoi();
		stim_done = 1;
	end

	// driver: bursts and gaps
	int gap_left, burst_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= 8'd0;
			end_of_input <= 1'b0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) predict_tokens('{char_code, end_of_input});
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				src_byte_t b;
				b = pending_bytes.pop_front();
				in_valid <= 1'b1;
				char_code <= b.ch;
				end_of_input <= b.eoi;
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(60, 0);
					gap_left <= $urandom_range(3, 0) ? 0 : $urandom_range(4, 1);
				end
			end else in_valid <= 1'b0;
		end
	end

	// receiver stall pattern and token check
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			out_stall <= (stall_phase[9:8] == 2'd3) ? 1'b0 :
				($urandom_range(3, 0) == 0);
			if (out_valid && !out_stall) begin
				tok_exp_t x;
				if (expected_tokens.size() == 0) begin
					$error("unexpected token kind %0d", token_kind);
					fail_count++;
				end else begin
					x = expected_tokens.pop_front();
					if (token_kind !== x.kind) begin
						$error("token_kind exp %0d got %0d", x.kind, token_kind);
						fail_count++;
					end
					if (type_name !== x.tname) begin
						$error("type_name exp %0d got %0d", x.tname, type_name);
						fail_count++;
					end
					if (start_line !== x.line) begin
						$error("start_line exp %0d got %0d", x.line, start_line);
						fail_count++;
					end
					if (start_column !== x.column) begin
						$error("start_column exp %0d got %0d", x.column, start_column);
						fail_count++;
					end
					if (token_length !== x.length) begin
						$error("token_length exp %0d got %0d", x.length, token_length);
						fail_count++;
					end
					if (number_value !== x.value) begin
						$error("number_value exp %0d got %0d", x.value, number_value);
						fail_count++;
					end
					if (error_code !== x.err) begin
						$error("error_code exp %0d got %0d", x.err, error_code);
						fail_count++;
					end
					if (last_of_run !== x.last) begin
						$error("last_of_run exp %0d got %0d", x.last, last_of_run);
						fail_count++;
					end
				end
			end
		end
	end

	// reset, then wait for the stream to drain
	initial begin
		lx_reset();
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (pending_bytes.size() > 0 || in_valid || expected_tokens.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("[source_text_tokenizer] OK");
		else $display("[source_text_tokenizer] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("[source_text_tokenizer] ERROR");
		$finish;
	end

endmodule
